[rtl/core/odm_pkg.sv]
`timescale 1ns / 1ps

package odm_pkg;

  // Field widths
  localparam int LEVEL_W   = 8;
  localparam int DOT_X_W   = 12;
  localparam int DOT_Y_W   = 16;
  localparam int ROW_W     = 16;
  localparam int ROW_IDX_W = 4;
  localparam int THRESH_W  = 9;
  localparam int SHIFT_W   = 3;

  // Stream widths, padded to whole bytes
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_SELECT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_SHIFT      = 2'd2;

  localparam logic [THRESH_W-1:0] THRESHOLD_RST = 9'h1FF;
  localparam logic [SHIFT_W-1:0]  MAG_SHIFT_RST = 3'd1;
  localparam logic [SHIFT_W-1:0]  SHIFT_MIN     = 3'd1;
  localparam logic [SHIFT_W-1:0]  SHIFT_MAX     = 3'd4;

  localparam int MAX_MAG_DEF = 16;

  // Pattern tables, indexed {x mod 8, y mod 8}
  localparam logic [7:0] HALFTONE_TBL [0:63] = '{
    8'd6,   8'd7,   8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13,
    8'd40,  8'd42,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,  8'd14,
    8'd37,  8'd112, 8'd118, 8'd124, 8'd130, 8'd137, 8'd57,  8'd15,
    8'd36,  8'd106, 8'd208, 8'd219, 8'd230, 8'd145, 8'd60,  8'd16,
    8'd34,  8'd101, 8'd197, 8'd254, 8'd243, 8'd152, 8'd63,  8'd17,
    8'd32,  8'd96,  8'd187, 8'd178, 8'd169, 8'd160, 8'd66,  8'd18,
    8'd30,  8'd91,  8'd86,  8'd82,  8'd78,  8'd74,  8'd70,  8'd19,
    8'd29,  8'd27,  8'd26,  8'd25,  8'd23,  8'd22,  8'd21,  8'd20
  };

  localparam logic [7:0] DITHER_TBL [0:63] = '{
    8'd6,   8'd51,  8'd14,  8'd78,  8'd8,   8'd57,  8'd16,  8'd86,
    8'd118, 8'd22,  8'd178, 8'd34,  8'd130, 8'd25,  8'd197, 8'd37,
    8'd18,  8'd96,  8'd10,  8'd63,  8'd20,  8'd106, 8'd12,  8'd70,
    8'd219, 8'd42,  8'd145, 8'd27,  8'd243, 8'd46,  8'd160, 8'd30,
    8'd9,   8'd60,  8'd17,  8'd91,  8'd7,   8'd54,  8'd15,  8'd82,
    8'd137, 8'd26,  8'd208, 8'd40,  8'd124, 8'd23,  8'd187, 8'd36,
    8'd21,  8'd112, 8'd13,  8'd74,  8'd19,  8'd101, 8'd11,  8'd66,
    8'd254, 8'd49,  8'd169, 8'd32,  8'd230, 8'd44,  8'd152, 8'd29
  };

endpackage

[rtl/core/ordered_dither_magnify_unit.sv]
`timescale 1ns / 1ps

// Ordered dither with magnification: one grey pixel in, its printer dot rows out.
// Input stream s_*: one pixel per item (level, dot_x, dot_y). Output stream m_*:
// one item per dot row (row_bits, row_index), tlast on the final row of a pixel.
// The user writes configuration through cfg_we/cfg_index/cfg_data only while idle;
// the block does not enforce it. Threshold mode (threshold >= 0) gives one row
// with one dot; pattern mode gives mag rows of mag dots, mag = 2^mag_shift
// clamped to 2..MAX_MAG. The first row of a pixel passes through the held-pixel
// registers and then the output register onto m_*. Throughput: one row per cycle
// while the output is not stalled; the row counter over the held pixel steps
// through its rows. The next pixel is taken in the cycle the last row of the current
// one is loaded, so rows of consecutive pixels leave back to back.
// A stalled output holds its row in the output register; the held pixel then
// waits, and s_tready stays low until its last row can be loaded.
// Reset empties both registers and sets threshold -1 (pattern mode),
// pattern_select 0 (dither) and mag_shift 1.
module ordered_dither_magnify_unit
  import odm_pkg::*;
#(
  parameter int MAX_MAG = MAX_MAG_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // pixel input
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // level[7:0], dot_x[19:8], dot_y[35:20]
  // dot row output
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // row_bits[15:0], row_index[19:16]
  output logic                  m_tlast    // last_row
);

  localparam int RW        = $clog2(MAX_MAG);
  localparam int MAX_SHIFT = $clog2(MAX_MAG + 1) - 1;

  // Configuration registers
  logic [THRESH_W-1:0] threshold;
  logic                pattern_select;
  logic [SHIFT_W-1:0]  mag_shift;

  // Held pixel
  logic               busy;
  logic [LEVEL_W-1:0] level_q;
  logic [2:0]         dx_q;
  logic [3:0]         dy_q;
  logic [RW-1:0]      my;

  // Row logic
  logic               pattern_mode;
  logic [SHIFT_W-1:0] eff_shift;
  logic [RW-1:0]      mag_m1;
  logic               last_now;
  logic               advance;
  logic               in_accept;
  logic [3:0]         py;
  logic               shift_x;
  logic [ROW_W-1:0]   lane_dot;
  logic [ROW_W-1:0]   row_bits;
  logic [2:0]         px;
  logic [5:0]         tbl_idx;
  logic [7:0]         tval;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= THRESHOLD_RST;
      pattern_select <= 1'b0;
      mag_shift      <= MAG_SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:      threshold      <= cfg_data[THRESH_W-1:0];
        REG_PATTERN_SELECT: pattern_select <= cfg_data[0];
        REG_MAG_SHIFT:      mag_shift      <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the magnification shift to the supported range
  always_comb begin
    if (mag_shift < SHIFT_MIN) begin
      eff_shift = SHIFT_MIN;
    end else if (mag_shift > SHIFT_MAX) begin
      eff_shift = SHIFT_MAX;
    end else begin
      eff_shift = mag_shift;
    end
    if (eff_shift > SHIFT_W'(MAX_SHIFT)) begin
      eff_shift = SHIFT_W'(MAX_SHIFT);
    end
  end

  assign pattern_mode = threshold[THRESH_W-1];
  assign mag_m1       = RW'((5'd1 << eff_shift) - 5'd1);
  assign last_now     = !pattern_mode || (my == mag_m1);
  assign advance      = busy && (!m_tvalid || m_tready);
  assign s_tready     = !busy || (advance && last_now);
  assign in_accept    = s_tvalid && s_tready;

  // Look up one threshold per dot of the current row
  assign py      = dy_q + 4'(my);
  assign shift_x = pattern_select && py[3];

  always_comb begin
    px       = '0;
    tbl_idx  = '0;
    tval     = '0;
    lane_dot = '0;
    for (int mx = 0; mx < ROW_W; mx++) begin
      px      = dx_q + 3'(mx) + (shift_x ? 3'd4 : 3'd0);
      tbl_idx = {px, py[2:0]};
      tval    = pattern_select ? HALFTONE_TBL[tbl_idx] : DITHER_TBL[tbl_idx];
      lane_dot[mx] = level_q < tval;
    end
  end

  // Place dot mx at bit mag-1-mx, or the single threshold dot at bit 0
  always_comb begin
    row_bits = '0;
    if (!pattern_mode) begin
      row_bits[0] = level_q < threshold[LEVEL_W-1:0];
    end else begin
      for (int s = 1; s <= 4; s++) begin
        if (eff_shift == SHIFT_W'(s)) begin
          for (int b = 0; b < (1 << s); b++) begin
            row_bits[b] = lane_dot[(1 << s) - 1 - b];
          end
        end
      end
    end
  end

  // Hold the pixel and step through its rows
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      my   <= '0;
    end else if (in_accept) begin
      busy <= 1'b1;
      my   <= '0;
    end else if (advance && last_now) begin
      busy <= 1'b0;
    end else if (advance) begin
      my <= my + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      level_q <= s_tdata[7:0];
      dx_q    <= s_tdata[10:8];
      dy_q    <= s_tdata[23:20];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'b0, ROW_IDX_W'(my), row_bits};
      m_tlast <= last_now;
    end
  end

  // A taken pixel starts at row zero
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> busy && (my == '0))
    else $error("pixel not loaded at row zero");

  // A row that is not the last keeps the pixel and moves to the next row
  assert property (@(posedge clk) disable iff (rst)
    (advance && !last_now) |=> busy && (my == $past(my) + RW'(1)))
    else $error("row counter did not advance");

  // Rows are only loaded while a pixel is held
  assert property (@(posedge clk) disable iff (rst)
    (!busy && !$past(busy)) |-> !$rose(m_tvalid))
    else $error("row produced without a pixel");

endmodule

[tb/odm_checker.sv]
`timescale 1ns / 1ps

package odm_tb_pkg;

  // Pattern table choice, as written to the pattern_select register
  localparam logic PAT_DITHER   = 1'b0;
  localparam logic PAT_HALFTONE = 1'b1;

  // Register index with no register behind it
  localparam logic [1:0] REG_SPARE = 2'd3;

  // One dot row as it should leave the block
  typedef struct packed {
    logic [15:0] bits;
    logic [3:0]  idx;
    logic        last;
  } dot_row_t;

endpackage

module odm_checker
  import odm_pkg::*;
  import odm_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // level[7:0], dot_x[19:8], dot_y[35:20]
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // row_bits[15:0], row_index[19:16]
  input  logic                  m_tlast,   // last_row
  output int                    fail_count,
  output int                    pending
);

  localparam int MAG_LIMIT = MAX_MAG_DEF;

  // Threshold tables, first index is x mod 8, second y mod 8
  localparam logic [7:0] CLUSTERED_TBL [0:7][0:7] = '{
    '{8'd6,   8'd7,   8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13},
    '{8'd40,  8'd42,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,  8'd14},
    '{8'd37,  8'd112, 8'd118, 8'd124, 8'd130, 8'd137, 8'd57,  8'd15},
    '{8'd36,  8'd106, 8'd208, 8'd219, 8'd230, 8'd145, 8'd60,  8'd16},
    '{8'd34,  8'd101, 8'd197, 8'd254, 8'd243, 8'd152, 8'd63,  8'd17},
    '{8'd32,  8'd96,  8'd187, 8'd178, 8'd169, 8'd160, 8'd66,  8'd18},
    '{8'd30,  8'd91,  8'd86,  8'd82,  8'd78,  8'd74,  8'd70,  8'd19},
    '{8'd29,  8'd27,  8'd26,  8'd25,  8'd23,  8'd22,  8'd21,  8'd20}
  };

  localparam logic [7:0] DISPERSED_TBL [0:7][0:7] = '{
    '{8'd6,   8'd51,  8'd14,  8'd78,  8'd8,   8'd57,  8'd16,  8'd86},
    '{8'd118, 8'd22,  8'd178, 8'd34,  8'd130, 8'd25,  8'd197, 8'd37},
    '{8'd18,  8'd96,  8'd10,  8'd63,  8'd20,  8'd106, 8'd12,  8'd70},
    '{8'd219, 8'd42,  8'd145, 8'd27,  8'd243, 8'd46,  8'd160, 8'd30},
    '{8'd9,   8'd60,  8'd17,  8'd91,  8'd7,   8'd54,  8'd15,  8'd82},
    '{8'd137, 8'd26,  8'd208, 8'd40,  8'd124, 8'd23,  8'd187, 8'd36},
    '{8'd21,  8'd112, 8'd13,  8'd74,  8'd19,  8'd101, 8'd11,  8'd66},
    '{8'd254, 8'd49,  8'd169, 8'd32,  8'd230, 8'd44,  8'd152, 8'd29}
  };

  // Shadow of the configuration registers
  logic [THRESH_W-1:0] thresh_q;
  logic                pattern_q;
  logic [SHIFT_W-1:0]  shift_q;

  dot_row_t expected_rows [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= 25)
      $display("dot row mismatch on %s: got %0h, expected %0h", what, got, want);
  endtask

  // Work out every dot row of one pixel and queue them in order
  function automatic void queue_pixel_rows(input logic [LEVEL_W-1:0] level,
                                           input logic [DOT_X_W-1:0] dot_x,
                                           input logic [DOT_Y_W-1:0] dot_y);
    dot_row_t            row;
    int                  shift;
    int                  mag;
    logic [DOT_X_W-1:0]  px;
    logic [DOT_Y_W-1:0]  py;
    logic [7:0]          limit;

    // threshold mode: one dot, one row
    if (!thresh_q[THRESH_W-1]) begin
      row.bits = (level < thresh_q[7:0]) ? 16'd1 : 16'd0;
      row.idx  = 4'd0;
      row.last = 1'b1;
      expected_rows.push_back(row);
      return;
    end

    // clamp the magnification to what the block supports
    shift = int'(shift_q);
    if (shift < 1) shift = 1;
    if (shift > 4) shift = 4;
    while (shift > 1 && (1 << shift) > MAG_LIMIT) shift--;
    mag = 1 << shift;

    for (int my = 0; my < mag; my++) begin
      py = dot_y + DOT_Y_W'(my);
      row.bits = '0;
      for (int mx = 0; mx < mag; mx++) begin
        px = dot_x + DOT_X_W'(mx);
        // clustered screen is offset by half a cell on alternate bands
        if (pattern_q == PAT_HALFTONE && py[3]) px = px + DOT_X_W'(4);
        limit = (pattern_q == PAT_HALFTONE) ? CLUSTERED_TBL[px[2:0]][py[2:0]]
                                            : DISPERSED_TBL[px[2:0]][py[2:0]];
        row.bits = {row.bits[14:0], level < limit};
      end
      row.idx  = 4'(my);
      row.last = (my == mag - 1);
      expected_rows.push_back(row);
    end
  endfunction

  always @(posedge clk) begin
    dot_row_t want;
    if (rst) begin
      thresh_q  = THRESHOLD_RST;
      pattern_q = PAT_DITHER;
      shift_q   = MAG_SHIFT_RST;
      expected_rows.delete();
    end else begin
      // compare a delivered row with the oldest one due
      if (m_tvalid && m_tready) begin
        if (expected_rows.size() == 0) begin
          report("unexpected row", int'(m_tdata), 0);
        end else begin
          want = expected_rows.pop_front();
          if (m_tdata[ROW_W-1:0] != want.bits)
            report("row_bits", int'(m_tdata[ROW_W-1:0]), int'(want.bits));
          if (m_tdata[ROW_W+ROW_IDX_W-1:ROW_W] != want.idx)
            report("row_index", int'(m_tdata[ROW_W+ROW_IDX_W-1:ROW_W]), int'(want.idx));
          if (m_tlast != want.last)
            report("last_row", int'(m_tlast), int'(want.last));
          if (m_tdata[OUT_DATA_W-1:ROW_W+ROW_IDX_W] != '0)
            report("tdata padding", int'(m_tdata[OUT_DATA_W-1:ROW_W+ROW_IDX_W]), 0);
        end
      end

      // predict the rows of an accepted pixel
      if (s_tvalid && s_tready)
        queue_pixel_rows(s_tdata[LEVEL_W-1:0],
                         s_tdata[LEVEL_W+DOT_X_W-1:LEVEL_W],
                         s_tdata[LEVEL_W+DOT_X_W+DOT_Y_W-1:LEVEL_W+DOT_X_W]);

      // track register writes; unknown indexes change nothing
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD:      thresh_q  = cfg_data[THRESH_W-1:0];
          REG_PATTERN_SELECT: pattern_q = cfg_data[0];
          REG_MAG_SHIFT:      shift_q   = cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_rows.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import odm_pkg::*;
  import odm_tb_pkg::*;

  localparam int LONG_HOLD    = 80;
  localparam int RANDOM_ITEMS = 345;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // level[7:0], dot_x[19:8], dot_y[35:20]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // row_bits[15:0], row_index[19:16]
  logic                  m_tlast;        // last_row

  int fail_count;
  int pending;
  int pixels_sent = 0;
  int quiet_items = 0;
  int holds_asked = 0;
  bit calm = 1'b0;

  ordered_dither_magnify_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  odm_checker dot_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("ordered_dither_magnify_unit verification failed");
    $finish;
  end

  // Dot side: random stall bursts, quiet stretches, and long holds on request
  initial begin
    int stall_left;
    int run_left;
    int hold_left;
    int holds_served;
    stall_left   = 0;
    run_left     = 0;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_served < holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        m_tready <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        m_tready <= 1'b0;
      end else begin
        run_left = $urandom_range(0, 30);
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one pixel, maybe after an idle burst, and hold it until taken
  task automatic send_pixel(input logic [LEVEL_W-1:0] level,
                            input logic [DOT_X_W-1:0] dot_x,
                            input logic [DOT_Y_W-1:0] dot_y);
    int gap;
    gap = 0;
    if (!calm) begin
      if (quiet_items > 0) quiet_items--;
      else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 12);
      else quiet_items = $urandom_range(0, 20);
    end
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - LEVEL_W - DOT_X_W - DOT_Y_W){1'b0}}, dot_y, dot_x, level};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixels_sent++;
  endtask

  // Pixel with random content, extremes of the grey scale now and then
  task automatic send_random_pixel();
    logic [LEVEL_W-1:0] level;
    level = LEVEL_W'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) level = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    send_pixel(level, DOT_X_W'($urandom_range(0, 4095)), DOT_Y_W'($urandom()));
  endtask

  // Stop offering and wait for every due row, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random register setting for one phase, mostly pattern mode
  task automatic write_random_config();
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 255)));
    else
      write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(256, 511)));
    write_reg(REG_PATTERN_SELECT,
              CFG_DATA_W'($urandom_range(0, 1) ? PAT_HALFTONE : PAT_DITHER));
    write_reg(REG_MAG_SHIFT, CFG_DATA_W'($urandom_range(0, 7)));
    if ($urandom_range(0, 5) == 0)
      write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 511)));
  endtask

  initial begin
    int phase;
    int items;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // pattern mode out of reset: dispersed table, 2x2 dots
    send_pixel(8'd0, 12'd0, 16'd0);
    send_pixel(8'd255, 12'hFFF, 16'hFFFF);
    send_pixel(8'd100, 12'd6, 16'd3);

    // threshold mode at both ends of the range
    write_reg(REG_THRESHOLD, 9'd0);
    send_pixel(8'd0, 12'd17, 16'd9);
    write_reg(REG_THRESHOLD, 9'd255);
    send_pixel(8'd0, 12'd0, 16'd0);
    send_pixel(8'd254, 12'hFFF, 16'hFFFF);
    send_pixel(8'd255, 12'd1, 16'd1);
    write_reg(REG_THRESHOLD, 9'd128);
    send_pixel(8'd127, 12'd2, 16'd2);
    send_pixel(8'd128, 12'd3, 16'd3);

    // write to an unused index leaves the threshold alone
    write_reg(REG_SPARE, 9'h1FF);
    send_pixel(8'd127, 12'd4, 16'd4);

    // most negative threshold, halftone, shift of zero runs as 2x2
    write_reg(REG_THRESHOLD, 9'h100);
    write_reg(REG_PATTERN_SELECT, CFG_DATA_W'(PAT_HALFTONE));
    write_reg(REG_MAG_SHIFT, 9'd0);
    send_pixel(8'd100, 12'd3, 16'd7);
    send_pixel(8'd50, 12'd0, 16'd8);

    // 16x16 with x and y wrapping across the shifted halftone band
    write_reg(REG_MAG_SHIFT, 9'd4);
    send_pixel(8'd128, 12'hFFC, 16'hFFF8);
    send_pixel(8'd0, 12'd0, 16'd0);
    send_pixel(8'd255, 12'd9, 16'd5);

    // oversized shift clamps to 16x16
    write_reg(REG_MAG_SHIFT, 9'd7);
    send_pixel(8'd200, 12'd5, 16'd8);

    write_reg(REG_MAG_SHIFT, 9'd2);
    send_pixel(8'd60, 12'd2, 16'd5);
    write_reg(REG_MAG_SHIFT, 9'd3);
    send_pixel(8'd120, 12'd4093, 16'd65533);

    // back to the dispersed table with threshold -1
    write_reg(REG_PATTERN_SELECT, CFG_DATA_W'(PAT_DITHER));
    write_reg(REG_THRESHOLD, 9'h1FF);
    send_pixel(8'd90, 12'd7, 16'd1);
    write_reg(REG_MAG_SHIFT, 9'd5);
    send_pixel(8'd30, 12'd1, 16'd2);

    // random phases, each under its own register setting
    phase = 0;
    while (pixels_sent < RANDOM_ITEMS) begin
      if (phase == 2) begin
        // fill the block while the dot side holds off
        write_reg(REG_THRESHOLD, 9'h1FF);
        write_reg(REG_PATTERN_SELECT,
                  CFG_DATA_W'($urandom_range(0, 1) ? PAT_HALFTONE : PAT_DITHER));
        write_reg(REG_MAG_SHIFT, 9'd4);
        holds_asked++;
        repeat (20) send_random_pixel();
      end else begin
        write_random_config();
        items = $urandom_range(8, 30);
        repeat (items) send_random_pixel();
      end
      phase++;
    end

    // closing stretch with both sides streaming flat out
    write_random_config();
    calm = 1'b1;
    repeat (35) send_random_pixel();

    settle();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ordered_dither_magnify_unit verification clean");
    end else begin
      $display("ordered_dither_magnify_unit verification failed");
    end
    $finish;
  end

endmodule
